>>> rtl/core/sts_pkg.sv
// Shared types, constants and the tanh table builder for the stereo tanh saturator.
// No dependencies; every other file of the block imports this package.
package sts_pkg;

  // Width of the configuration coefficients and of the filter alpha (Q0.16).
  localparam int COEF_W = 16;
  // Drive gain 1 + 8*drive in Q.16 needs twenty bits.
  localparam int GAIN_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int PRESHAPE_W = 14;

  localparam logic [COEF_W-1:0] DRIVE_BYPASS = 16'd65;
  localparam logic [COEF_W-1:0] TONE_RESET = 16'd32768;
  localparam logic [COEF_W-1:0] RATE_RESET = 16'd16384;
  localparam logic [COEF_W-1:0] ALPHA_BASE = 16'd3277;
  localparam logic [COEF_W-1:0] ALPHA_SPAN = 16'd55706;
  localparam logic [COEF_W-1:0] ALPHA_MIN = 16'd328;
  localparam logic [COEF_W-1:0] ALPHA_MAX = 16'd64881;
  localparam logic [COEF_W:0] MIX_ONE = 17'h10000;
  // 0.15 in Q0.16.
  localparam logic [PRESHAPE_W-1:0] PRESHAPE_K = 14'd9830;

  // 1.05, 3.3333 and 1.6667 in Q.32, scaled down to the sample format where used.
  localparam logic [63:0] Q32_CLAMP = 64'd4509715661;
  localparam logic [63:0] Q32_THRESH = 64'd14316414289;
  localparam logic [63:0] Q32_FLOOR_U = 64'd7158419792;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE  = 2'd0,
    CFG_TONE   = 2'd1,
    CFG_RATE   = 2'd2,
    CFG_ENABLE = 2'd3
  } sts_cfg_idx_e;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_GAIN,
    STEP_SQUARE,
    STEP_SCALE,
    STEP_INDEX,
    STEP_INTERP,
    STEP_FILTER,
    STEP_MIX,
    STEP_SUM
  } sts_step_e;

  typedef struct packed {
    sts_step_e step;
    logic      load;
    logic      bypass;
  } sts_ctrl_t;

  // Unsigned long division by shift and subtract, one quotient bit per pass.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One table entry, tanh(4*i/depth) in Q.fb, rounded. The caller supplies
  // i/depth in Q.32. The exponential comes from a series of exp(-z) up to z^14,
  // raised to the sixteenth power by repeated squaring.
  function automatic logic [63:0] tanh_entry(logic [63:0] tq, int unsigned fb);
    logic [63:0]        z;
    logic [63:0]        mag;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [63:0] sum;
    z   = tq >> 3;
    sum = 64'sd1 <<< 30;
    mag = 64'd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      // Dropping the 2^30 first and then dividing by k floors the same way.
      mag = udiv64((mag * z) >> 30, 64'(k));
      if (k[0]) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    e = $unsigned(sum);
    for (int k = 0; k < 4; k++) begin
      e = (e * e) >> 30;
    end
    num = ((64'd1 << 30) - e) << 30;
    den = (64'd1 << 30) + e;
    num = udiv64(num, den);
    return (num + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

>>> rtl/core/sts_if.sv
// Valid/ready channel interfaces of the stereo tanh saturator: input, result, configuration.
// Depends on sts_pkg for the configuration widths.
interface sts_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          block_last;

  modport source (output valid, sample_left, sample_right, block_last, input ready);
  modport sink (input valid, sample_left, sample_right, block_last, output ready);
endinterface

interface sts_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          out_last;

  modport source (output valid, out_left, out_right, out_last, input ready);
  modport sink (input valid, out_left, out_right, out_last, output ready);
endinterface

interface sts_cfg_if import sts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/sts_tanh_rom.sv
// Constant tanh table with two read ports: the addressed entry and the one after it.
// Depends on sts_pkg for the entry builder; contents are fixed at elaboration.
module sts_tanh_rom import sts_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic [$clog2(TANH_TABLE_DEPTH)-1:0] idx_i,
  output logic [SAMPLE_BITS-3:0]              lo_o,
  output logic [SAMPLE_BITS-3:0]              hi_o
);

  localparam int FB = SAMPLE_BITS - 3;
  localparam int EW = FB + 1;
  localparam int IXW = $clog2(TANH_TABLE_DEPTH);

  logic [EW-1:0]  rom_w [TANH_TABLE_DEPTH];
  logic [IXW-1:0] hi_idx;

  for (genvar gi = 0; gi < TANH_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] TQ = (64'(gi) << 32) / TANH_TABLE_DEPTH;
    localparam logic [63:0] ENTRY = tanh_entry(TQ, FB);
    assign rom_w[gi] = ENTRY[EW-1:0];
  end

  // The last entry is its own neighbour, so the slope there reads as zero.
  assign hi_idx = (idx_i == IXW'(TANH_TABLE_DEPTH - 1)) ? idx_i : idx_i + IXW'(1);
  assign lo_o   = rom_w[idx_i];
  assign hi_o   = rom_w[hi_idx];

endmodule

>>> rtl/core/sts_lane.sv
// One channel of the saturator: gain, quadratic pre-shape, table tanh, tone filter and mix.
// Depends on sts_pkg and sts_tanh_rom; sequenced by the control struct from the top level.
module sts_lane import sts_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sts_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [GAIN_W-1:0]             gain_i,
  input  logic [COEF_W-1:0]             alpha_i,
  input  logic [COEF_W-1:0]             tone_i,
  output logic [SAMPLE_BITS-1:0]        result_o
);

  localparam int S = SAMPLE_BITS;
  localparam int FB = S - 3;
  localparam int PW = S + GAIN_W + 1;
  localparam int XFW = PW - 16;
  localparam int XW = S + 1;
  localparam int SQW = 2 * S - 1;
  localparam int SQSW = SQW - FB;
  localparam int QW = SQSW + PRESHAPE_W;
  localparam int UW = S + 1;
  localparam int DW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int POSW = S + DW;
  localparam int FRW = FB + 2;
  localparam int FIW = POSW - FRW;
  localparam int IXW = $clog2(TANH_TABLE_DEPTH);
  localparam int EW = FB + 1;
  localparam int DPW = EW + FRW;
  localparam int APW = S + COEF_W + 1;
  localparam int MW = S + COEF_W + 2;
  localparam int SUMW = MW + 1;
  localparam int SHW = SUMW - 16;

  localparam logic signed [XFW-1:0] LIM = XFW'(64'd1 << (S - 1));
  localparam logic signed [63:0] THR64 = -$signed(Q32_THRESH >> (32 - FB));
  localparam logic signed [63:0] UFL64 = -$signed(Q32_FLOOR_U >> (32 - FB));
  localparam logic signed [XW-1:0] THR = THR64[XW-1:0];
  localparam logic signed [UW-1:0] UFL = UFL64[UW-1:0];
  localparam logic signed [SHW-1:0] CLAMPV = SHW'(Q32_CLAMP >> (32 - FB));

  logic signed [S-1:0]    s_q;
  logic signed [PW-1:0]   p0_q;
  logic signed [XW-1:0]   x_q;
  logic [SQW-1:0]         sqp_q;
  logic [QW-1:0]          q_q;
  logic [IXW-1:0]         idx_q;
  logic [FRW-1:0]         frac_q;
  logic                   neg_q;
  logic [EW-1:0]          lo_q;
  logic [DPW-1:0]         dfp_q;
  logic signed [S-1:0]    sat_q;
  logic signed [APW-1:0]  ap_q;
  logic signed [S-1:0]    st_q;
  logic signed [S-1:0]    st_d;
  logic signed [MW-1:0]   ma_q;
  logic signed [MW-1:0]   mb_q;

  logic signed [PW-1:0]   p0_w;
  logic signed [XFW-1:0]  xf_w;
  logic signed [XFW-1:0]  xc_w;
  logic signed [2*XW-1:0] sq_full_w;
  logic [S+1:0]           u_sum_w;
  logic signed [UW-1:0]   u_w;
  logic [UW-1:0]          u_abs_w;
  logic [POSW-1:0]        pos_w;
  logic [FIW-1:0]         idx_full_w;
  logic [EW-1:0]          lo_w;
  logic [EW-1:0]          hi_w;
  logic [EW-1:0]          r_w;
  logic signed [S-1:0]    r_s_w;
  logic signed [S-1:0]    sat_w;
  logic signed [S-1:0]    diff_w;
  logic signed [APW-1:0]  ap_w;
  logic [S:0]             st_sum_w;
  logic [COEF_W:0]        inv_tone_w;
  logic signed [MW-1:0]   ma_w;
  logic signed [MW-1:0]   mb_w;
  logic signed [SUMW-1:0] sum_w;
  logic signed [SHW-1:0]  sh_w;
  logic signed [SHW-1:0]  shc_w;

  sts_tanh_rom #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_rom (
    .idx_i (idx_q),
    .lo_o  (lo_w),
    .hi_o  (hi_w)
  );

  // Gain and its saturation to plus or minus four.
  assign p0_w = sample_i * $signed({1'b0, gain_i});
  assign xf_w = p0_q[PW-1:16];
  always_comb begin
    if (xf_w > LIM) begin
      xc_w = LIM;
    end else if (xf_w < -LIM) begin
      xc_w = -LIM;
    end else begin
      xc_w = xf_w;
    end
  end
  assign sq_full_w = $signed(xc_w[XW-1:0]) * $signed(xc_w[XW-1:0]);

  // Pre-shape below the threshold is the fixed floor value.
  assign u_sum_w = {x_q[XW-1], x_q} + {2'b00, q_q[QW-1:16]};
  assign u_w     = (x_q >= THR) ? $signed(u_sum_w[UW-1:0]) : UFL;
  assign u_abs_w = u_w[UW-1] ? UW'(-u_w) : UW'(u_w);
  assign pos_w   = POSW'(u_abs_w[S-1:0]) * POSW'(TANH_TABLE_DEPTH);
  assign idx_full_w = pos_w[POSW-1:FRW];

  // Interpolation, then the sign of the pre-shaped value comes back.
  assign r_w    = lo_q + EW'(dfp_q >> FRW);
  assign r_s_w  = S'(r_w);
  assign sat_w  = neg_q ? -r_s_w : r_s_w;
  assign diff_w = sat_w - st_q;
  assign ap_w   = $signed({1'b0, alpha_i}) * diff_w;

  assign st_sum_w = {st_q[S-1], st_q} + ap_q[APW-1:16];

  assign inv_tone_w = MIX_ONE - {1'b0, tone_i};
  assign ma_w = $signed({1'b0, inv_tone_w}) * st_q;
  assign mb_w = $signed({1'b0, tone_i}) * sat_q;

  assign sum_w = SUMW'(ma_q) + SUMW'(mb_q);
  assign sh_w  = sum_w[SUMW-1:16];
  always_comb begin
    if (sh_w > CLAMPV) begin
      shc_w = CLAMPV;
    end else if (sh_w < -CLAMPV) begin
      shc_w = -CLAMPV;
    end else begin
      shc_w = sh_w;
    end
  end

  assign result_o = ctrl_i.bypass ? s_q : shc_w[S-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      s_q  <= sample_i;
      p0_q <= p0_w;
    end
    if (ctrl_i.step == STEP_GAIN) begin
      x_q   <= xc_w[XW-1:0];
      sqp_q <= sq_full_w[SQW-1:0];
    end
    if (ctrl_i.step == STEP_SQUARE) begin
      q_q <= QW'(sqp_q[SQW-1:FB]) * QW'(PRESHAPE_K);
    end
    if (ctrl_i.step == STEP_SCALE) begin
      neg_q <= u_w[UW-1];
      // Beyond the last entry the table value is flat.
      if (idx_full_w >= FIW'(TANH_TABLE_DEPTH - 1)) begin
        idx_q  <= IXW'(TANH_TABLE_DEPTH - 1);
        frac_q <= '0;
      end else begin
        idx_q  <= idx_full_w[IXW-1:0];
        frac_q <= pos_w[FRW-1:0];
      end
    end
    if (ctrl_i.step == STEP_INDEX) begin
      lo_q  <= lo_w;
      dfp_q <= DPW'(hi_w - lo_w) * DPW'(frac_q);
    end
    if (ctrl_i.step == STEP_INTERP) begin
      sat_q <= sat_w;
      ap_q  <= ap_w;
    end
    if (ctrl_i.step == STEP_MIX) begin
      ma_q <= ma_w;
      mb_q <= mb_w;
    end
  end

  // The filter state moves once per processed item; bypassed items leave it alone.
  always_comb begin
    st_d = st_q;
    if (ctrl_i.step == STEP_FILTER && !ctrl_i.bypass) begin
      st_d = $signed(st_sum_w[S-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

>>> rtl/core/stereo_tanh_saturator_tone_unit.sv
// Top level of the stereo tanh saturator: configuration registers, sequencer, two lanes
// and the output register that merges them. Depends on sts_pkg, sts_if and sts_lane.
//
// Each accepted item is a left/right pair in signed Q2.F. Both channels run in their own
// lane at the same time: drive gain, quadratic pre-shape, interpolated tanh table, one-pole
// tone filter and a saturated/filtered crossfade clamped to plus or minus 1.05. The sequencer
// walks both lanes through eight steps after the accepting edge; the last step, SUM, loads
// the result into the output register, and only then does the sequencer return to idle and
// take a new item. The chain of multipliers behind each filter update sets the number of
// steps. A finished result waits in the output register while the next item is taken; if
// that register is still full when the next result is ready, the lanes hold it until the
// register frees. Bypassed items (unit disabled, or drive at or below 65/65536) take the
// same path, return the input bits unchanged and leave the filter state alone.
// Configuration writes are always accepted and should be made while the unit is idle.
module stereo_tanh_saturator_tone_unit import sts_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sts_in_if.sink    in_i,
  sts_cfg_if.sink   cfg_i,
  sts_out_if.source out_o
);

  logic [COEF_W-1:0]   drive_q;
  logic [COEF_W-1:0]   tone_q;
  logic [COEF_W-1:0]   rate_q;
  logic                enable_q;
  logic [COEF_W-1:0]   base_q;
  logic [COEF_W-1:0]   alpha_q;
  logic [COEF_W-1:0]   alpha_d;
  logic [2*COEF_W-1:0] base_prod_w;
  logic [COEF_W:0]     base_sum_w;
  logic [2*COEF_W-1:0] alpha_prod_w;
  logic [GAIN_W-1:0]   gain_w;

  sts_step_e state_q;
  sts_step_e state_d;
  sts_ctrl_t ctrl;
  logic      bypass_q;
  logic      last_q;
  logic      in_ready;
  logic      out_free;
  logic      out_load;
  logic      out_valid_q;

  logic [SAMPLE_BITS-1:0] res_left_w;
  logic [SAMPLE_BITS-1:0] res_right_w;
  logic [SAMPLE_BITS-1:0] out_left_q;
  logic [SAMPLE_BITS-1:0] out_right_q;
  logic                   out_last_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q  <= '0;
      tone_q   <= TONE_RESET;
      rate_q   <= RATE_RESET;
      enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (sts_cfg_idx_e'(cfg_i.index))
        CFG_DRIVE:  drive_q  <= cfg_i.data;
        CFG_TONE:   tone_q   <= cfg_i.data;
        CFG_RATE:   rate_q   <= cfg_i.data;
        CFG_ENABLE: enable_q <= cfg_i.data[0];
        default:    ;
      endcase
    end
  end

  // Filter coefficient, refreshed every cycle over two registered multiplies.
  assign base_prod_w  = tone_q * ALPHA_SPAN;
  assign base_sum_w   = {1'b0, ALPHA_BASE} + {1'b0, base_prod_w[2*COEF_W-1:COEF_W]};
  assign alpha_prod_w = base_q * rate_q;

  always_comb begin
    if (alpha_prod_w[2*COEF_W-1:14] < (2*COEF_W-14)'(ALPHA_MIN)) begin
      alpha_d = ALPHA_MIN;
    end else if (alpha_prod_w[2*COEF_W-1:14] > (2*COEF_W-14)'(ALPHA_MAX)) begin
      alpha_d = ALPHA_MAX;
    end else begin
      alpha_d = alpha_prod_w[COEF_W+13:14];
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_sum_w[COEF_W-1:0];
    alpha_q <= alpha_d;
  end

  assign gain_w = GAIN_W'(20'h10000) + {1'b0, drive_q, 3'b000};

  // Sequencer.
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      STEP_IDLE:   if (in_i.valid) state_d = STEP_GAIN;
      STEP_GAIN:   state_d = STEP_SQUARE;
      STEP_SQUARE: state_d = STEP_SCALE;
      STEP_SCALE:  state_d = STEP_INDEX;
      STEP_INDEX:  state_d = STEP_INTERP;
      STEP_INTERP: state_d = STEP_FILTER;
      STEP_FILTER: state_d = STEP_MIX;
      STEP_MIX:    state_d = STEP_SUM;
      STEP_SUM:    if (out_free) state_d = STEP_IDLE;
      default:     state_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_q == STEP_IDLE);
    out_load    = (state_q == STEP_SUM) && out_free;
    ctrl.step   = state_q;
    ctrl.load   = in_ready && in_i.valid;
    ctrl.bypass = bypass_q;
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= STEP_IDLE;
      bypass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.load) begin
        bypass_q <= !enable_q || (drive_q <= DRIVE_BYPASS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      last_q <= in_i.block_last;
    end
  end

  sts_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.sample_left),
    .gain_i   (gain_w),
    .alpha_i  (alpha_q),
    .tone_i   (tone_q),
    .result_o (res_left_w)
  );

  sts_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_i.sample_right),
    .gain_i   (gain_w),
    .alpha_i  (alpha_q),
    .tone_i   (tone_q),
    .result_o (res_right_w)
  );

  // Output register: both lanes and the block marker leave as one item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= res_left_w;
      out_right_q <= res_right_w;
      out_last_q  <= last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;
  assign out_o.out_last  = out_last_q;

endmodule
